/* rtl/agsct_pkg.sv */
// Shared types, constants and helpers for the gear shift and clutch timer.
package agsct_pkg;

  localparam int MAX_GEARS  = 8;
  localparam int TIME_BITS  = 24;
  localparam int FIELD_W    = 24;
  localparam int RPM_W      = 16;
  localparam int THR_W      = 16;
  localparam int CNT_W      = 4;
  localparam int GEAR_W     = 5;
  localparam int GEAR_CMP_W = GEAR_W + 1;
  localparam int FRIC_W     = 17;
  localparam int Q_BITS     = 16;
  localparam int DIV_CNT_W  = $clog2(Q_BITS);
  localparam int CFG_IDX_W  = 3;

  localparam logic [FRIC_W-1:0] FULL_FRICTION = FRIC_W'(1) << Q_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AUTO_MODE,
    REG_FWD_COUNT,
    REG_REV_COUNT,
    REG_UP_RPM,
    REG_DOWN_RPM,
    REG_SWITCH_DUR,
    REG_RELEASE_DUR,
    REG_SHIFT_LAT
  } cfg_reg_t;

  typedef struct packed {
    logic                 auto_mode;
    logic [CNT_W-1:0]     fwd_count;
    logic [CNT_W-1:0]     rev_count;
    logic [RPM_W-1:0]     up_rpm;
    logic [RPM_W-1:0]     down_rpm;
    logic [TIME_BITS-1:0] switch_dur;
    logic [TIME_BITS-1:0] release_dur;
    logic [TIME_BITS-1:0] shift_lat;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic div_step;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_sts_t;

  function automatic logic [TIME_BITS-1:0] to_time(input logic [FIELD_W-1:0] v);
    logic [TIME_BITS-1:0] r;
    for (int i = 0; i < TIME_BITS; i++) begin
      r[i] = (i < FIELD_W) ? v[i] : 1'b0;
    end
    return r;
  endfunction

  function automatic logic [TIME_BITS-1:0] sat_sub(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n);
    return (n > CNT_W'(MAX_GEARS)) ? CNT_W'(MAX_GEARS) : n;
  endfunction

endpackage

/* rtl/agsct_cfg.sv */
// Configuration register bank.
module agsct_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [agsct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [agsct_pkg::FIELD_W-1:0]   cfg_wdata,
  output agsct_pkg::cfg_t                 cfg_o
);
  import agsct_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AUTO_MODE:   cfg_nxt.auto_mode   = cfg_wdata[0];
        REG_FWD_COUNT:   cfg_nxt.fwd_count   = cfg_wdata[CNT_W-1:0];
        REG_REV_COUNT:   cfg_nxt.rev_count   = cfg_wdata[CNT_W-1:0];
        REG_UP_RPM:      cfg_nxt.up_rpm      = cfg_wdata[RPM_W-1:0];
        REG_DOWN_RPM:    cfg_nxt.down_rpm    = cfg_wdata[RPM_W-1:0];
        REG_SWITCH_DUR:  cfg_nxt.switch_dur  = to_time(cfg_wdata);
        REG_RELEASE_DUR: cfg_nxt.release_dur = to_time(cfg_wdata);
        REG_SHIFT_LAT:   cfg_nxt.shift_lat   = to_time(cfg_wdata);
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.auto_mode   <= 1'b1;
      cfg_r.fwd_count   <= CNT_W'(5);
      cfg_r.rev_count   <= CNT_W'(1);
      cfg_r.up_rpm      <= RPM_W'(4000);
      cfg_r.down_rpm    <= RPM_W'(2000);
      cfg_r.switch_dur  <= to_time(FIELD_W'(500000));
      cfg_r.release_dur <= to_time(FIELD_W'(300000));
      cfg_r.shift_lat   <= to_time(FIELD_W'(500000));
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

/* rtl/agsct_ctrl.sv */
// Sequencing state machine: accept, evaluate, divide, deliver.
module agsct_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  agsct_pkg::dp_sts_t sts,
  output agsct_pkg::dp_cmd_t cmd
);
  import agsct_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = sts.need_div ? ST_DIV : ST_DONE;
      ST_DIV:  if (sts.div_last) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load     = (state_r == ST_IDLE) && in_valid;
    cmd.eval     = (state_r == ST_EVAL);
    cmd.div_step = (state_r == ST_DIV);
    cmd.publish  = (state_r == ST_DONE) && out_free;
    in_ready     = (state_r == ST_IDLE);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/agsct_dp.sv */
// Datapath: gear selection, countdown timers, restoring divider, output word.
module agsct_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  agsct_pkg::cfg_t                   cfg,
  input  agsct_pkg::dp_cmd_t                cmd,
  output agsct_pkg::dp_sts_t                sts,
  input  logic [agsct_pkg::FIELD_W-1:0]     in_delta_time,
  input  logic [agsct_pkg::RPM_W-1:0]       in_engine_rpm,
  input  logic signed [agsct_pkg::THR_W-1:0] in_throttle_dir,
  input  logic                              in_upshift_allowed,
  output logic signed [agsct_pkg::GEAR_W-1:0] out_gear_now,
  output logic [agsct_pkg::FRIC_W-1:0]      out_clutch_engage
);
  import agsct_pkg::*;

  // latched word
  logic [FIELD_W-1:0]       dt_r;
  logic [RPM_W-1:0]         rpm_r;
  logic signed [THR_W-1:0]  thr_r;
  logic                     up_r;

  // block state
  logic signed [GEAR_W-1:0] gear_r, gear_nxt;
  logic [FRIC_W-1:0]        fric_r, fric_nxt;
  logic [TIME_BITS-1:0]     sw_r, sw_nxt;
  logic [TIME_BITS-1:0]     rel_r, rel_nxt;
  logic [TIME_BITS-1:0]     lat_r, lat_nxt;

  // divider
  logic [TIME_BITS-1:0]     rem_r, rem_nxt;
  logic [Q_BITS-1:0]        q_r, q_nxt;
  logic [DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [TIME_BITS:0]       rem2;
  logic                     ge;

  logic signed [GEAR_W-1:0] out_gear_r;
  logic [FRIC_W-1:0]        out_fric_r;

  logic signed [GEAR_CMP_W-1:0] g, g_new, fwd_n, rev_n, dir, top, bottom;
  logic [TIME_BITS-1:0]     dt, rel_sub;
  logic                     changed, need_div;

  assign dt = to_time(dt_r);

  // gear choice
  always_comb begin
    g      = GEAR_CMP_W'(gear_r);
    fwd_n  = signed'({2'b00, clamp_count(cfg.fwd_count)});
    rev_n  = signed'({2'b00, clamp_count(cfg.rev_count)});
    if (thr_r == '0) begin
      dir = '0;
    end else if (thr_r[THR_W-1]) begin
      dir = -GEAR_CMP_W'(1);
    end else begin
      dir = GEAR_CMP_W'(1);
    end
    top    = (dir != '0) ? -GEAR_CMP_W'(1) : '0;
    bottom = (dir != '0) ? GEAR_CMP_W'(1) : '0;
    g_new  = g;
    priority if (g == '0 || (dir > 0 && g < 0) || (dir < 0 && g > 0)) begin
      g_new = dir;
    end else if (lat_r == '0) begin
      priority if (up_r && rpm_r > cfg.up_rpm) begin
        if (g < 0) begin
          if (g > -rev_n) g_new = g - GEAR_CMP_W'(1);
        end else begin
          if (g < fwd_n) g_new = g + GEAR_CMP_W'(1);
        end
      end else if (rpm_r < cfg.down_rpm) begin
        if (g < 0) begin
          if (g < top) g_new = g + GEAR_CMP_W'(1);
        end else begin
          if (g > bottom) g_new = g - GEAR_CMP_W'(1);
        end
      end else begin
        g_new = g;
      end
    end else begin
      g_new = g;
    end
  end

  assign changed  = (g_new != g);
  assign rel_sub  = sat_sub(rel_r, dt);
  assign need_div = cfg.auto_mode && !changed && (sw_r == '0) && (rel_r != '0)
                    && (rel_sub < cfg.release_dur);

  assign rem2 = {rem_r, 1'b0};
  assign ge   = (rem2 >= {1'b0, cfg.release_dur});

  always_comb begin
    gear_nxt = gear_r;
    fric_nxt = fric_r;
    sw_nxt   = sw_r;
    rel_nxt  = rel_r;
    lat_nxt  = lat_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    if (cmd.eval && cfg.auto_mode) begin
      gear_nxt = GEAR_W'(g_new);
      priority if (changed) begin
        sw_nxt   = (g != '0) ? cfg.switch_dur : '0;
        rel_nxt  = cfg.release_dur;
        lat_nxt  = cfg.shift_lat;
        fric_nxt = '0;
      end else if (sw_r != '0) begin
        sw_nxt   = sat_sub(sw_r, dt);
        fric_nxt = '0;
      end else if (rel_r != '0) begin
        rel_nxt  = rel_sub;
        fric_nxt = '0;
        rem_nxt  = rel_sub;
        q_nxt    = '0;
        cnt_nxt  = '0;
      end else begin
        fric_nxt = FULL_FRICTION;
        lat_nxt  = sat_sub(lat_r, dt);
      end
    end
    if (cmd.div_step) begin
      rem_nxt = ge ? TIME_BITS'(rem2 - {1'b0, cfg.release_dur}) : TIME_BITS'(rem2);
      q_nxt   = {q_r[Q_BITS-2:0], ge};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (sts.div_last) begin
        fric_nxt = FULL_FRICTION - {1'b0, q_nxt};
      end
    end
  end

  assign sts.need_div = need_div;
  assign sts.div_last = (cnt_r == DIV_CNT_W'(Q_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gear_r <= '0;
      fric_r <= '0;
      sw_r   <= '0;
      rel_r  <= '0;
      lat_r  <= '0;
      cnt_r  <= '0;
    end else begin
      gear_r <= gear_nxt;
      fric_r <= fric_nxt;
      sw_r   <= sw_nxt;
      rel_r  <= rel_nxt;
      lat_r  <= lat_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (cmd.load) begin
      dt_r  <= in_delta_time;
      rpm_r <= in_engine_rpm;
      thr_r <= in_throttle_dir;
      up_r  <= in_upshift_allowed;
    end
    if (cmd.publish) begin
      out_gear_r <= gear_r;
      out_fric_r <= fric_r;
    end
  end

  assign out_gear_now      = out_gear_r;
  assign out_clutch_engage = out_fric_r;

endmodule

/* rtl/auto_gear_shift_clutch_timer.sv */
// Top level of the automatic gear shift and clutch timer.
//
// One input word per control tick: delta_time, engine_rpm, throttle_dir and
// upshift_allowed, on a valid/ready channel. Each accepted word gives exactly
// one result word (gear_now, clutch_engage) on a valid/ready output channel.
// Configuration registers are to be written through cfg_we/cfg_index/cfg_wdata
// only while the block is idle (index 0..7 in cfg_reg_t order); the block itself
// does not enforce this. From input acceptance to out_valid a word passes the
// EVAL and DONE states, and DIV too while the clutch release ramp runs, where a
// restoring divider makes the 16-bit quotient of the engagement fraction one
// quotient bit per cycle. in_ready is high only while idle, so a word is taken
// only after the last is published, even while that result still waits. A
// stalled receiver holds the result in the output register; the block then
// finishes at most one further word and waits for the register to free.
// Reset (synchronous, rst_n low) returns the gear to neutral, clears all
// timers and friction, and loads the register defaults.
module auto_gear_shift_clutch_timer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [agsct_pkg::FIELD_W-1:0]     in_delta_time,
  input  logic [agsct_pkg::RPM_W-1:0]       in_engine_rpm,
  input  logic signed [agsct_pkg::THR_W-1:0] in_throttle_dir,
  input  logic                              in_upshift_allowed,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [agsct_pkg::GEAR_W-1:0] out_gear_now,
  output logic [agsct_pkg::FRIC_W-1:0]      out_clutch_engage,
  input  logic                              cfg_we,
  input  logic [agsct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [agsct_pkg::FIELD_W-1:0]     cfg_wdata
);
  import agsct_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  agsct_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  agsct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  agsct_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .cmd                (cmd),
    .sts                (sts),
    .in_delta_time      (in_delta_time),
    .in_engine_rpm      (in_engine_rpm),
    .in_throttle_dir    (in_throttle_dir),
    .in_upshift_allowed (in_upshift_allowed),
    .out_gear_now       (out_gear_now),
    .out_clutch_engage  (out_clutch_engage)
  );

endmodule

/* rtl/agsct_checker.sv */
// Port-level checks for the gear shift and clutch timer, bound to the top level.
module agsct_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [agsct_pkg::GEAR_W-1:0] out_gear_now,
  input logic [agsct_pkg::FRIC_W-1:0]      out_clutch_engage
);
  import agsct_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while previous one in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_gear_now)
                               && $stable(out_clutch_engage))
    else $error("stalled result word changed");

  a_fric_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_clutch_engage <= FULL_FRICTION)
    else $error("clutch fraction above full");

  a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_gear_now <= GEAR_W'(MAX_GEARS))
                  && (out_gear_now >= -GEAR_W'(MAX_GEARS)))
    else $error("gear out of range");

endmodule

bind auto_gear_shift_clutch_timer agsct_checker u_agsct_checker (.*);

/* tb/auto_gear_shift_clutch_timer_tb.sv */
// Self-checking testbench for the automatic gear shift and clutch timer.
`timescale 1ns / 100ps

module auto_gear_shift_clutch_timer_tb;
  import agsct_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int PLAN_LEN    = 38;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic [GEAR_W-1:0] gear;
    logic [FRIC_W-1:0] clutch;
  } gear_word_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [FIELD_W-1:0]   dt;
    logic [RPM_W-1:0]     rpm;
    logic [THR_W-1:0]     thr;
    logic                 up;
    cfg_reg_t             idx;
    logic [FIELD_W-1:0]   val;
    logic                 chk;
    logic [GEAR_W-1:0]    gear;
    logic [FRIC_W-1:0]    clutch;
  } plan_row_t;

  // directed stimulus; chk rows carry a hand-written expected word
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{ROW_ITEM, 24'd1000,     16'd0,     16'h0000, 1'b0, REG_AUTO_MODE, 24'd0, 1'b1, 5'd0,  17'd65536},
    '{ROW_ITEM, 24'd0,        16'd65535, 16'h7FFF, 1'b1, REG_AUTO_MODE, 24'd0, 1'b1, 5'd1,  17'd0},
    '{ROW_ITEM, 24'd0,        16'd3000,  16'h8000, 1'b0, REG_AUTO_MODE, 24'd0, 1'b1, -5'sd1, 17'd0},
    '{ROW_ITEM, 24'hFFFFFF,   16'd3000,  16'h0000, 1'b1, REG_AUTO_MODE, 24'd0, 1'b1, -5'sd1, 17'd0},
    '{ROW_ITEM, 24'hFFFFFF,   16'd3000,  16'h0000, 1'b0, REG_AUTO_MODE, 24'd0, 1'b1, -5'sd1,
      17'd65536},
    '{ROW_ITEM, 24'hFFFFFF,   16'd3000,  16'h0000, 1'b0, REG_AUTO_MODE, 24'd0, 1'b1, -5'sd1,
      17'd65536},
    '{ROW_ITEM, 24'd12345,    16'd65535, 16'hFFFF, 1'b1, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0},
    '{ROW_ITEM, 24'd0,        16'd100,   16'h0001, 1'b0, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0},
    '{ROW_ITEM, 24'd100000,   16'd2500,  16'h4000, 1'b1, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0},
    '{ROW_ITEM, 24'hFFFFFF,   16'd2500,  16'h4000, 1'b0, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0},
    '{ROW_ITEM, 24'd100000,   16'd2500,  16'h4000, 1'b0, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0},
    '{ROW_CFG,  24'd0, 16'd0, 16'h0000, 1'b0, REG_RELEASE_DUR, 24'd100000, 1'b0, 5'd0, 17'd0},
    '{ROW_ITEM, 24'd5,        16'd2500,  16'h4000, 1'b0, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0},
    '{ROW_CFG,  24'd0, 16'd0, 16'h0000, 1'b0, REG_RELEASE_DUR, 24'd0,      1'b0, 5'd0, 17'd0},
    '{ROW_CFG,  24'd0, 16'd0, 16'h0000, 1'b0, REG_SWITCH_DUR,  24'd0,      1'b0, 5'd0, 17'd0},
    '{ROW_CFG,  24'd0, 16'd0, 16'h0000, 1'b0, REG_SHIFT_LAT,   24'd0,      1'b0, 5'd0, 17'd0},
    '{ROW_ITEM, 24'hFFFFFF,   16'd2500,  16'h4000, 1'b0, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0},
    '{ROW_ITEM, 24'hFFFFFF,   16'd2500,  16'h4000, 1'b0, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0},
    '{ROW_ITEM, 24'd0,        16'd65535, 16'h7FFF, 1'b1, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0},
    '{ROW_CFG,  24'd0, 16'd0, 16'h0000, 1'b0, REG_FWD_COUNT,   24'd15,     1'b0, 5'd0, 17'd0},
    '{ROW_CFG,  24'd0, 16'd0, 16'h0000, 1'b0, REG_REV_COUNT,   24'd0,      1'b0, 5'd0, 17'd0},
    '{ROW_CFG,  24'd0, 16'd0, 16'h0000, 1'b0, REG_UP_RPM,      24'd0,      1'b0, 5'd0, 17'd0},
    '{ROW_CFG,  24'd0, 16'd0, 16'h0000, 1'b0, REG_DOWN_RPM,    24'd65535,  1'b0, 5'd0, 17'd0},
    '{ROW_ITEM, 24'd1,        16'd65535, 16'h7FFF, 1'b1, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0},
    '{ROW_ITEM, 24'd1,        16'd65535, 16'h7FFF, 1'b1, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0},
    '{ROW_ITEM, 24'd1,        16'd65535, 16'h7FFF, 1'b1, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0},
    '{ROW_ITEM, 24'd1,        16'd65535, 16'h7FFF, 1'b1, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0},
    '{ROW_ITEM, 24'd1,        16'd65535, 16'h7FFF, 1'b1, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0},
    '{ROW_ITEM, 24'd1,        16'd65535, 16'h7FFF, 1'b1, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0},
    '{ROW_ITEM, 24'd1,        16'd65535, 16'h7FFF, 1'b1, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0},
    '{ROW_ITEM, 24'd2,        16'd0,     16'h7FFF, 1'b1, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0},
    '{ROW_CFG,  24'd0, 16'd0, 16'h0000, 1'b0, REG_AUTO_MODE,   24'd0,      1'b0, 5'd0, 17'd0},
    '{ROW_ITEM, 24'hFFFFFF,   16'd65535, 16'h8000, 1'b1, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0},
    '{ROW_CFG,  24'd0, 16'd0, 16'h0000, 1'b0, REG_AUTO_MODE,   24'd1,      1'b0, 5'd0, 17'd0},
    '{ROW_ITEM, 24'd3,        16'd40000, 16'h8000, 1'b0, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0},
    '{ROW_ITEM, 24'd3,        16'd0,     16'h0000, 1'b0, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0},
    '{ROW_CFG,  24'd0, 16'd0, 16'h0000, 1'b0, REG_FWD_COUNT,   24'd0,      1'b0, 5'd0, 17'd0},
    '{ROW_ITEM, 24'd3,        16'd0,     16'h0001, 1'b0, REG_AUTO_MODE, 24'd0, 1'b0, 5'd0,  17'd0}
  };

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [FIELD_W-1:0]        in_delta_time;
  logic [RPM_W-1:0]          in_engine_rpm;
  logic signed [THR_W-1:0]   in_throttle_dir;
  logic                      in_upshift_allowed;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [GEAR_W-1:0]  out_gear_now;
  logic [FRIC_W-1:0]         out_clutch_engage;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [FIELD_W-1:0]        cfg_wdata;

  auto_gear_shift_clutch_timer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_delta_time      (in_delta_time),
    .in_engine_rpm      (in_engine_rpm),
    .in_throttle_dir    (in_throttle_dir),
    .in_upshift_allowed (in_upshift_allowed),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_gear_now       (out_gear_now),
    .out_clutch_engage  (out_clutch_engage),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // register copies
  logic                 c_auto;
  logic [CNT_W-1:0]     c_fwd;
  logic [CNT_W-1:0]     c_rev;
  logic [RPM_W-1:0]     c_up;
  logic [RPM_W-1:0]     c_down;
  logic [TIME_BITS-1:0] c_sw_dur;
  logic [TIME_BITS-1:0] c_rel_dur;
  logic [TIME_BITS-1:0] c_lat;

  // gearbox state
  int                   m_gear;
  logic [FRIC_W-1:0]    m_fric;
  logic [TIME_BITS-1:0] m_sw;
  logic [TIME_BITS-1:0] m_rel;
  logic [TIME_BITS-1:0] m_lat;

  gear_word_t expected_words [$];
  gear_word_t got_word;
  int         errors;
  int         cycles;
  int         tx_idle;
  int         rx_idle;
  bit         hold_go;

  function automatic logic [TIME_BITS-1:0] time_left(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  task automatic step_gearbox(input logic [FIELD_W-1:0] dt, input logic [RPM_W-1:0] rpm,
                              input logic [THR_W-1:0] thr, input logic up,
                              output gear_word_t res);
    int dir, prev, fwd_n, rev_n, lim;
    logic [TIME_BITS+Q_BITS-1:0] quo;
    dir = (thr == '0) ? 0 : (thr[THR_W-1] ? -1 : 1);
    if (c_auto) begin
      prev  = m_gear;
      fwd_n = (c_fwd > MAX_GEARS) ? MAX_GEARS : int'(c_fwd);
      rev_n = (c_rev > MAX_GEARS) ? MAX_GEARS : int'(c_rev);
      if (m_gear == 0 || (dir > 0 && m_gear < 0) || (dir < 0 && m_gear > 0)) begin
        m_gear = dir;
      end else if (m_lat == '0) begin
        if (up && rpm > c_up) begin
          if (m_gear < 0) begin
            if (m_gear > -rev_n) m_gear--;
          end else if (m_gear < fwd_n) begin
            m_gear++;
          end
        end else if (rpm < c_down) begin
          if (m_gear < 0) begin
            lim = (dir != 0) ? -1 : 0;
            if (m_gear < lim) m_gear++;
          end else begin
            lim = (dir != 0) ? 1 : 0;
            if (m_gear > lim) m_gear--;
          end
        end
      end
      if (prev != m_gear) begin
        m_sw   = (prev != 0) ? c_sw_dur : '0;
        m_rel  = c_rel_dur;
        m_lat  = c_lat;
        m_fric = '0;
      end else if (m_sw != '0) begin
        m_sw   = time_left(m_sw, dt);
        m_fric = '0;
      end else if (m_rel != '0) begin
        m_rel = time_left(m_rel, dt);
        if (m_rel >= c_rel_dur) begin
          m_fric = '0;
        end else begin
          quo    = {m_rel, {Q_BITS{1'b0}}} / {{Q_BITS{1'b0}}, c_rel_dur};
          m_fric = FULL_FRICTION - quo[FRIC_W-1:0];
        end
      end else begin
        m_fric = FULL_FRICTION;
        m_lat  = time_left(m_lat, dt);
      end
    end
    res.gear   = GEAR_W'(m_gear);
    res.clutch = m_fric;
  endtask

  task automatic send_word(input logic [FIELD_W-1:0] dt, input logic [RPM_W-1:0] rpm,
                           input logic [THR_W-1:0] thr, input logic up,
                           input logic chk, input gear_word_t typed);
    gear_word_t p;
    in_valid           <= 1'b1;
    in_delta_time      <= dt;
    in_engine_rpm      <= rpm;
    in_throttle_dir    <= thr;
    in_upshift_allowed <= up;
    do @(posedge clk); while (!in_ready);
    step_gearbox(dt, rpm, thr, up, p);
    expected_words.push_back(chk ? typed : p);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [FIELD_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_AUTO_MODE:   c_auto    = v[0];
      REG_FWD_COUNT:   c_fwd     = v[CNT_W-1:0];
      REG_REV_COUNT:   c_rev     = v[CNT_W-1:0];
      REG_UP_RPM:      c_up      = v[RPM_W-1:0];
      REG_DOWN_RPM:    c_down    = v[RPM_W-1:0];
      REG_SWITCH_DUR:  c_sw_dur  = v[TIME_BITS-1:0];
      REG_RELEASE_DUR: c_rel_dur = v[TIME_BITS-1:0];
      REG_SHIFT_LAT:   c_lat     = v[TIME_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word gear_now %0d clutch_engage %0d", $time,
                 out_gear_now, out_clutch_engage);
        errors = errors + 1;
      end else begin
        got_word = expected_words.pop_front();
        if (out_gear_now !== got_word.gear) begin
          $display("%0t: gear_now expected %0d got %0d", $time, $signed(got_word.gear),
                   out_gear_now);
          errors = errors + 1;
        end
        if (out_clutch_engage !== got_word.clutch) begin
          $display("%0t: clutch_engage expected %0d got %0d", $time, got_word.clutch,
                   out_clutch_engage);
          errors = errors + 1;
        end
      end
    end
  end

  // receiver
  initial begin : rx_side
    int n;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        out_ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_go = 1'b0;
      end
      out_ready <= rst_n && ($urandom_range(99) >= rx_idle);
    end
  end

  initial begin : tx_side
    int ph, k, r, cur_dir, nitems, dt_hi, rv;
    logic [FIELD_W-1:0] dt, val;
    logic [RPM_W-1:0]   rpm;
    logic [THR_W-1:0]   thr;
    logic               up;
    gear_word_t         typed;

    errors  = 0;
    cycles  = 0;
    hold_go = 1'b0;
    tx_idle = 19;
    rx_idle = 58;
    c_auto = 1'b1;  c_fwd = 4'd5;  c_rev = 4'd1;  c_up = 16'd4000;  c_down = 16'd2000;
    c_sw_dur = 24'd500000;  c_rel_dur = 24'd300000;  c_lat = 24'd500000;
    m_gear = 0;  m_fric = '0;  m_sw = '0;  m_rel = '0;  m_lat = '0;

    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_delta_time      <= '0;
    in_engine_rpm      <= '0;
    in_throttle_dir    <= '0;
    in_upshift_allowed <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_AUTO_MODE;
    cfg_wdata          <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        drain();
        write_reg(PLAN[i].idx, PLAN[i].val);
      end else begin
        typed.gear   = PLAN[i].gear;
        typed.clutch = PLAN[i].clutch;
        send_word(PLAN[i].dt, PLAN[i].rpm, PLAN[i].thr, PLAN[i].up, PLAN[i].chk, typed);
      end
    end

    cur_dir = 1;
    typed   = '0;
    for (ph = 0; ph < 12; ph++) begin
      drain();
      tx_idle = (ph < 4) ? 19 : (ph < 8) ? 58 : 0;
      rx_idle = (ph < 4) ? 58 : (ph < 8) ? 19 : 0;
      for (r = 0; r < 8; r++) begin
        case (cfg_reg_t'(r))
          REG_AUTO_MODE: val = 24'(ph != 7);
          REG_FWD_COUNT, REG_REV_COUNT:
            val = (ph == 1) ? 24'd0 : (ph == 2) ? 24'd15 : 24'($urandom_range(0, 15));
          REG_UP_RPM:
            val = (ph == 1) ? 24'd0 : (ph == 2) ? 24'd65535 :
                  ($urandom_range(3) == 0) ? 24'($urandom_range(0, 65535)) :
                  24'($urandom_range(2000, 8000));
          REG_DOWN_RPM:
            val = (ph == 1) ? 24'd0 : (ph == 2) ? 24'd65535 :
                  ($urandom_range(3) == 0) ? 24'($urandom_range(0, 65535)) :
                  24'($urandom_range(500, 4000));
          default:
            val = (ph == 1) ? 24'd0 : (ph == 2) ? 24'hFFFFFF :
                  ($urandom_range(5) == 0) ? 24'd0 : 24'($urandom_range(0, 20000));
        endcase
        write_reg(cfg_reg_t'(r), val);
      end
      dt_hi  = int'(c_rel_dur / 8) + int'(c_sw_dur / 16) + 8;
      nitems = (ph == 7) ? 40 : 170;
      for (k = 0; k < nitems; k++) begin
        if (ph == 2 && k == 60) hold_go = 1'b1;
        if (ph == 5 && k == 80) drain();
        if ($urandom_range(99) < 6) cur_dir = int'($urandom_range(2)) - 1;
        case ($urandom_range(9))
          0:       dt = 24'($urandom);
          1:       dt = $urandom_range(1) ? 24'hFFFFFF : 24'd0;
          default: dt = 24'($urandom_range(0, dt_hi));
        endcase
        rv = int'($urandom_range(9));
        if (rv < 4) begin
          rv = int'(c_up) + int'($urandom_range(0, 600)) - 300;
        end else if (rv < 7) begin
          rv = int'(c_down) + int'($urandom_range(0, 600)) - 300;
        end else begin
          rv = int'($urandom_range(0, 65535));
        end
        rpm = (rv < 0) ? 16'd0 : (rv > 65535) ? 16'hFFFF : 16'(rv);
        if ($urandom_range(99) < 3) begin
          thr = 16'($urandom);
        end else if (cur_dir > 0) begin
          thr = 16'($urandom_range(1, 32767));
        end else if (cur_dir < 0) begin
          thr = 16'(-int'($urandom_range(1, 32768)));
        end else begin
          thr = '0;
        end
        up = ($urandom_range(99) < 75);
        send_word(dt, rpm, thr, up, 1'b0, typed);
      end
    end

    drain();
    repeat (25) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/agsct_pkg.sv
rtl/agsct_cfg.sv
rtl/agsct_ctrl.sv
rtl/agsct_dp.sv
rtl/auto_gear_shift_clutch_timer.sv
rtl/agsct_checker.sv
tb/auto_gear_shift_clutch_timer_tb.sv
